### rtl/core/h2fd_pkg.sv
// shared types, codes and constants for the http/2 deframer and frame checker
// no dependencies
`timescale 1ns / 1ps

package h2fd_pkg;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  frame_type;
    logic [7:0]  frame_flags;
    logic [30:0] stream_id;
    logic [23:0] frame_len;
    logic [7:0]  data_byte;
    logic        last;
    logic [3:0]  check_code;
  } h2fd_item_t;

  localparam logic [1:0] KindHeader  = 2'd0;
  localparam logic [1:0] KindPayload = 2'd1;
  localparam logic [1:0] KindFatal   = 2'd2;

  localparam logic [3:0] ChkOk        = 4'd0;
  localparam logic [3:0] ChkPreface   = 4'd1;
  localparam logic [3:0] ChkTooLarge  = 4'd2;
  localparam logic [3:0] ChkExpCont   = 4'd3;
  localparam logic [3:0] ChkStreamZero = 4'd4;
  localparam logic [3:0] ChkPushProm  = 4'd5;
  localparam logic [3:0] ChkSettings  = 4'd6;
  localparam logic [3:0] ChkWinUpdate = 4'd7;
  localparam logic [3:0] ChkRst       = 4'd8;
  localparam logic [3:0] ChkPing      = 4'd9;
  localparam logic [3:0] ChkGoaway    = 4'd10;

  localparam logic [7:0] TypeData     = 8'h00;
  localparam logic [7:0] TypeHeaders  = 8'h01;
  localparam logic [7:0] TypeRst      = 8'h03;
  localparam logic [7:0] TypeSettings = 8'h04;
  localparam logic [7:0] TypePushProm = 8'h05;
  localparam logic [7:0] TypePing     = 8'h06;
  localparam logic [7:0] TypeGoaway   = 8'h07;
  localparam logic [7:0] TypeWinUpd   = 8'h08;
  localparam logic [7:0] TypeCont     = 8'h09;

  localparam logic [7:0] FlagAck        = 8'h01;
  localparam logic [7:0] FlagEndHeaders = 8'h04;

  localparam logic CfgExpectPreface = 1'b0;
  localparam logic CfgMaxFrameLen   = 1'b1;

  localparam int         CfgWidth    = 24;
  localparam logic [4:0] PrefaceLen  = 5'd24;
  localparam logic [23:0] MaxLenReset = 24'd16384;
  localparam int         HdrBytes    = 9;
  localparam int         HdrCntW     = 4;
  localparam int         FifoDepth   = 4;
  localparam int         FifoAw      = $clog2(FifoDepth);

  function automatic logic [7:0] preface_byte(input logic [4:0] pos);
    logic [7:0] r;
    case (pos)
      5'd0:  r = 8'h50;
      5'd1:  r = 8'h52;
      5'd2:  r = 8'h49;
      5'd3:  r = 8'h20;
      5'd4:  r = 8'h2a;
      5'd5:  r = 8'h20;
      5'd6:  r = 8'h48;
      5'd7:  r = 8'h54;
      5'd8:  r = 8'h54;
      5'd9:  r = 8'h50;
      5'd10: r = 8'h2f;
      5'd11: r = 8'h32;
      5'd12: r = 8'h2e;
      5'd13: r = 8'h30;
      5'd14: r = 8'h0d;
      5'd15: r = 8'h0a;
      5'd16: r = 8'h0d;
      5'd17: r = 8'h0a;
      5'd18: r = 8'h53;
      5'd19: r = 8'h4d;
      5'd20: r = 8'h0d;
      5'd21: r = 8'h0a;
      5'd22: r = 8'h0d;
      5'd23: r = 8'h0a;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

### rtl/core/h2fd_front.sv
// front end: preface match, header assembly, payload counting, length limit
// depends on h2fd_pkg
`timescale 1ns / 1ps

module h2fd_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic                       cfg_idx,
  input  logic [h2fd_pkg::CfgWidth-1:0] cfg_data,
  input  logic                       acc,
  input  logic [7:0]                 in_byte,
  output logic                       push,
  output h2fd_pkg::h2fd_item_t       item
);

  logic        expect_pre_r;
  logic [23:0] max_len_r;
  logic        stopped_r, stopped_nxt;
  logic [4:0]  pre_cnt_r, pre_cnt_nxt;
  logic [h2fd_pkg::HdrCntW-1:0] hdr_cnt_r, hdr_cnt_nxt;
  logic [23:0] pay_left_r, pay_left_nxt;
  logic [7:0]  hdr_r [h2fd_pkg::HdrBytes];
  logic        hdr_wr;

  logic [23:0] new_len;
  logic [30:0] new_sid;
  logic [30:0] cur_sid;
  logic [7:0]  pre_exp;

  assign new_len = {hdr_r[0], hdr_r[1], hdr_r[2]};
  assign new_sid = {hdr_r[5][6:0], hdr_r[6], hdr_r[7], in_byte};
  assign cur_sid = {hdr_r[5][6:0], hdr_r[6], hdr_r[7], hdr_r[8]};
  assign pre_exp = h2fd_pkg::preface_byte(h2fd_pkg::PrefaceLen - pre_cnt_r);

  always_comb begin
    stopped_nxt  = stopped_r;
    pre_cnt_nxt  = pre_cnt_r;
    hdr_cnt_nxt  = hdr_cnt_r;
    pay_left_nxt = pay_left_r;
    hdr_wr       = 1'b0;
    push         = 1'b0;
    item         = '0;
    if (acc && !stopped_r) begin
      if (expect_pre_r && pre_cnt_r != 5'd0) begin
        if (in_byte != pre_exp) begin
          stopped_nxt     = 1'b1;
          push            = 1'b1;
          item.kind       = h2fd_pkg::KindFatal;
          item.check_code = h2fd_pkg::ChkPreface;
        end else begin
          pre_cnt_nxt = pre_cnt_r - 5'd1;
        end
      end else if (pay_left_r != 24'd0) begin
        pay_left_nxt     = pay_left_r - 24'd1;
        push             = 1'b1;
        item.kind        = h2fd_pkg::KindPayload;
        item.frame_type  = hdr_r[3];
        item.frame_flags = hdr_r[4];
        item.stream_id   = cur_sid;
        item.frame_len   = new_len;
        item.data_byte   = in_byte;
        item.last        = (pay_left_r == 24'd1);
      end else begin
        hdr_wr = 1'b1;
        if (hdr_cnt_r != h2fd_pkg::HdrCntW'(h2fd_pkg::HdrBytes - 1)) begin
          hdr_cnt_nxt = hdr_cnt_r + 1'b1;
        end else begin
          hdr_cnt_nxt      = '0;
          push             = 1'b1;
          item.frame_type  = hdr_r[3];
          item.frame_flags = hdr_r[4];
          item.stream_id   = new_sid;
          item.frame_len   = new_len;
          if (new_len > max_len_r) begin
            stopped_nxt     = 1'b1;
            item.kind       = h2fd_pkg::KindFatal;
            item.check_code = h2fd_pkg::ChkTooLarge;
          end else begin
            pay_left_nxt = new_len;
            item.kind    = h2fd_pkg::KindHeader;
            item.last    = (new_len == 24'd0);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expect_pre_r <= 1'b1;
      max_len_r    <= h2fd_pkg::MaxLenReset;
      stopped_r    <= 1'b0;
      pre_cnt_r    <= h2fd_pkg::PrefaceLen;
      hdr_cnt_r    <= '0;
      pay_left_r   <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          h2fd_pkg::CfgExpectPreface: expect_pre_r <= cfg_data[0];
          h2fd_pkg::CfgMaxFrameLen:   max_len_r    <= cfg_data[23:0];
          default: ;
        endcase
      end
      stopped_r  <= stopped_nxt;
      pre_cnt_r  <= pre_cnt_nxt;
      hdr_cnt_r  <= hdr_cnt_nxt;
      pay_left_r <= pay_left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (hdr_wr) begin
      hdr_r[hdr_cnt_r] <= in_byte;
    end
  end

endmodule

### rtl/core/h2fd_fifo.sv
// short queue of classified beats between front and back
// depends on h2fd_pkg
`timescale 1ns / 1ps

module h2fd_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  h2fd_pkg::h2fd_item_t wr_item,
  output logic                 full,
  input  logic                 rd_en,
  output h2fd_pkg::h2fd_item_t rd_item,
  output logic                 empty
);

  h2fd_pkg::h2fd_item_t mem_r [h2fd_pkg::FifoDepth];
  logic [h2fd_pkg::FifoAw-1:0] wr_ptr_r, rd_ptr_r;
  logic [h2fd_pkg::FifoAw:0]   cnt_r, cnt_nxt;

  assign full    = (cnt_r == (h2fd_pkg::FifoAw + 1)'(h2fd_pkg::FifoDepth));
  assign empty   = (cnt_r == '0);
  assign rd_item = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (wr_en && !rd_en) cnt_nxt = cnt_r + 1'b1;
    else if (!wr_en && rd_en) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (wr_en) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (rd_en) rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule

### rtl/core/h2fd_back.sv
// back end: frame checks, header block tracking and output register
// depends on h2fd_pkg
`timescale 1ns / 1ps

module h2fd_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_empty,
  input  h2fd_pkg::h2fd_item_t q_item,
  output logic                 q_rd,
  input  logic                 out_pop,
  output logic                 out_empty,
  output h2fd_pkg::h2fd_item_t out_item
);

  logic        out_valid_r;
  h2fd_pkg::h2fd_item_t out_item_r, item_nxt;
  logic        in_block_r, in_block_nxt;
  logic [30:0] blk_sid_r, blk_sid_nxt;
  logic        take;
  logic        sid_zero;
  logic [1:0]  len_mod3;

  function automatic logic [1:0] mod3_24(input logic [23:0] v);
    logic [9:0] a;
    logic [3:0] b;
    logic [2:0] c;
    logic [2:0] d;
    a = 10'(v[23:16]) + 10'(v[15:8]) + 10'(v[7:0]);
    b = 4'(a[9:8]) + 4'(a[7:6]) + 4'(a[5:4]) + 4'(a[3:2]) + 4'(a[1:0]);
    c = 3'(b[3:2]) + 3'(b[1:0]);
    d = 3'(c[2]) + 3'(c[1:0]);
    return (d >= 3'd3) ? 2'(d - 3'd3) : d[1:0];
  endfunction

  assign take      = !q_empty && (!out_valid_r || out_pop);
  assign q_rd      = take;
  assign out_empty = !out_valid_r;
  assign out_item  = out_item_r;
  assign sid_zero  = (q_item.stream_id == 31'd0);
  assign len_mod3  = mod3_24(q_item.frame_len);

  always_comb begin
    item_nxt     = q_item;
    in_block_nxt = in_block_r;
    blk_sid_nxt  = blk_sid_r;
    if (q_item.kind == h2fd_pkg::KindHeader) begin
      if (in_block_r && (q_item.frame_type != h2fd_pkg::TypeCont ||
                         q_item.stream_id != blk_sid_r)) begin
        item_nxt.check_code = h2fd_pkg::ChkExpCont;
      end else begin
        case (q_item.frame_type)
          h2fd_pkg::TypeData: begin
            item_nxt.check_code = sid_zero ? h2fd_pkg::ChkStreamZero : h2fd_pkg::ChkOk;
          end
          h2fd_pkg::TypeHeaders, h2fd_pkg::TypeCont: begin
            if (sid_zero) begin
              item_nxt.check_code = h2fd_pkg::ChkStreamZero;
            end else begin
              item_nxt.check_code = h2fd_pkg::ChkOk;
              in_block_nxt = (q_item.frame_flags & h2fd_pkg::FlagEndHeaders) == 8'h00;
              if (q_item.frame_type == h2fd_pkg::TypeHeaders) blk_sid_nxt = q_item.stream_id;
            end
          end
          h2fd_pkg::TypeRst: begin
            item_nxt.check_code = (q_item.frame_len != 24'd4 || sid_zero) ?
                                  h2fd_pkg::ChkRst : h2fd_pkg::ChkOk;
          end
          h2fd_pkg::TypeSettings: begin
            if ((q_item.frame_flags & h2fd_pkg::FlagAck) != 8'h00)
              item_nxt.check_code = h2fd_pkg::ChkOk;
            else
              item_nxt.check_code = (q_item.frame_len[0] || len_mod3 != 2'd0) ?
                                    h2fd_pkg::ChkSettings : h2fd_pkg::ChkOk;
          end
          h2fd_pkg::TypePushProm: item_nxt.check_code = h2fd_pkg::ChkPushProm;
          h2fd_pkg::TypePing: begin
            item_nxt.check_code = (q_item.frame_len != 24'd8) ?
                                  h2fd_pkg::ChkPing : h2fd_pkg::ChkOk;
          end
          h2fd_pkg::TypeGoaway: begin
            item_nxt.check_code = (q_item.frame_len < 24'd8) ?
                                  h2fd_pkg::ChkGoaway : h2fd_pkg::ChkOk;
          end
          h2fd_pkg::TypeWinUpd: begin
            item_nxt.check_code = (q_item.frame_len != 24'd4) ?
                                  h2fd_pkg::ChkWinUpdate : h2fd_pkg::ChkOk;
          end
          default: item_nxt.check_code = h2fd_pkg::ChkOk;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      in_block_r  <= 1'b0;
      blk_sid_r   <= '0;
    end else begin
      if (take) begin
        out_valid_r <= 1'b1;
        in_block_r  <= in_block_nxt;
        blk_sid_r   <= blk_sid_nxt;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_item_r <= item_nxt;
    end
  end

endmodule

### rtl/core/http2_frame_deframer_checker_unit.sv
// channel   dir  handshake        payload
// input     in   in_push/in_full  in_byte
// result    out  out_empty/out_pop out_kind .. out_check_code
// config    in   cfg_we           cfg_idx, cfg_data
//
// one byte per cycle sustained while in_full is low; a result passes through a four-entry
// queue between front and back and is then held in the output register
// rst_n is synchronous; it resets the stop latch, preface count and queue
// in_full follows the queue being full; a stalled output only stalls input
// once the queue has filled
`timescale 1ns / 1ps

module http2_frame_deframer_checker_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  logic [7:0]           in_byte,
  output logic                 out_empty,
  input  logic                 out_pop,
  output logic [1:0]           out_kind,
  output logic [7:0]           out_frame_type,
  output logic [7:0]           out_frame_flags,
  output logic [30:0]          out_stream_id,
  output logic [23:0]          out_frame_len,
  output logic [7:0]           out_data_byte,
  output logic                 out_last,
  output logic [3:0]           out_check_code,
  input  logic                 cfg_we,
  input  logic                 cfg_idx,
  input  logic [h2fd_pkg::CfgWidth-1:0] cfg_data
);

  logic                 acc;
  logic                 f_push;
  h2fd_pkg::h2fd_item_t f_item;
  logic                 q_full, q_empty, q_rd;
  h2fd_pkg::h2fd_item_t q_item;
  h2fd_pkg::h2fd_item_t o_item;

  assign in_full = q_full;
  assign acc     = in_push && !q_full;

  h2fd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_we  (cfg_we),
    .cfg_idx (cfg_idx),
    .cfg_data(cfg_data),
    .acc     (acc),
    .in_byte (in_byte),
    .push    (f_push),
    .item    (f_item)
  );

  h2fd_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (f_push),
    .wr_item(f_item),
    .full   (q_full),
    .rd_en  (q_rd),
    .rd_item(q_item),
    .empty  (q_empty)
  );

  h2fd_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_item   (q_item),
    .q_rd     (q_rd),
    .out_pop  (out_pop),
    .out_empty(out_empty),
    .out_item (o_item)
  );

  assign out_kind        = o_item.kind;
  assign out_frame_type  = o_item.frame_type;
  assign out_frame_flags = o_item.frame_flags;
  assign out_stream_id   = o_item.stream_id;
  assign out_frame_len   = o_item.frame_len;
  assign out_data_byte   = o_item.data_byte;
  assign out_last        = o_item.last;
  assign out_check_code  = o_item.check_code;

endmodule

### rtl/core/h2fd_checker.sv
// port-level assertions for the deframer, bound to the top level
// depends on h2fd_pkg and http2_frame_deframer_checker_unit
`timescale 1ns / 1ps

module h2fd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_empty,
  input logic        out_pop,
  input logic [1:0]  out_kind,
  input logic [7:0]  out_data_byte,
  input logic [23:0] out_frame_len,
  input logic        out_last,
  input logic [3:0]  out_check_code
);

  // waiting beat holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_kind) &&
      $stable(out_data_byte) && $stable(out_frame_len) && $stable(out_check_code)))
    else $error("result beat changed while stalled");

  a_rst_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> out_empty)
    else $error("result present straight after reset");

  a_payload_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_kind == h2fd_pkg::KindPayload) |-> out_check_code == h2fd_pkg::ChkOk)
    else $error("payload beat with check code");

  a_hdr_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_kind == h2fd_pkg::KindHeader) |-> (out_last == (out_frame_len == 24'd0)))
    else $error("header last flag does not match length");

  a_fatal: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_kind == h2fd_pkg::KindFatal) |->
      (!out_last && out_data_byte == 8'd0 &&
       (out_check_code == h2fd_pkg::ChkPreface || out_check_code == h2fd_pkg::ChkTooLarge)))
    else $error("malformed fatal stop beat");

endmodule

bind http2_frame_deframer_checker_unit h2fd_checker u_h2fd_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_empty     (out_empty),
  .out_pop       (out_pop),
  .out_kind      (out_kind),
  .out_data_byte (out_data_byte),
  .out_frame_len (out_frame_len),
  .out_last      (out_last),
  .out_check_code(out_check_code)
);

### verif/h2fd_frame_model_pkg.sv
// expected-beat tracker for the http/2 deframer and frame checker testbench
// depends on h2fd_pkg for the result struct, kinds, check codes and frame types
`timescale 1ns / 1ps

package h2fd_frame_model_pkg;

  import h2fd_pkg::*;

  localparam logic [8*24-1:0] PrefaceText =
    {"PRI * HTTP/2.0", 16'h0d0a, 16'h0d0a, "SM", 16'h0d0a, 16'h0d0a};

  function automatic logic [7:0] preface_char(input int pos);
    return PrefaceText[8*(23-pos) +: 8];
  endfunction

  class deframe_tracker;
    bit             want_preface;
    logic [23:0]    max_len;
    logic [4:0]     preface_due;
    logic [7:0]     hdr [HdrBytes];
    int             hdr_fill;
    logic [23:0]    body_left;
    bit             in_hdr_block;
    logic [30:0]    hdr_block_sid;
    bit             halted;
    h2fd_item_t     beats_due [$];
    int             mismatches;
    int             bytes_seen;
    int             headers_seen;
    int             payload_seen;
    logic [15:0]    codes_seen;
    logic [3:0]     stop_code;

    function new();
      want_preface  = 1'b1;
      max_len       = MaxLenReset;
      preface_due   = PrefaceLen;
      hdr_fill      = 0;
      body_left     = '0;
      in_hdr_block  = 1'b0;
      hdr_block_sid = '0;
      halted        = 1'b0;
      mismatches    = 0;
      bytes_seen    = 0;
      headers_seen  = 0;
      payload_seen  = 0;
      codes_seen    = '0;
      stop_code     = ChkOk;
      foreach (hdr[i]) hdr[i] = '0;
    endfunction

    function void set_reg(input logic idx, input logic [CfgWidth-1:0] v);
      if (idx == CfgExpectPreface) begin
        want_preface = v[0];
      end else begin
        max_len = v;
      end
    endfunction

    function int pending();
      return beats_due.size();
    endfunction

    function void queue_beat(input h2fd_item_t r);
      beats_due.insert(beats_due.size(), r);
    endfunction

    function void report(input string msg);
      mismatches++;
      if (mismatches <= 100) begin
        $display("[%0t] check failed: %s", $time, msg);
      end
    endfunction

    function h2fd_item_t stamp(input logic [1:0] k);
      h2fd_item_t r;
      r             = '0;
      r.kind        = k;
      r.frame_type  = hdr[3];
      r.frame_flags = hdr[4];
      r.stream_id   = {hdr[5][6:0], hdr[6], hdr[7], hdr[8]};
      r.frame_len   = {hdr[0], hdr[1], hdr[2]};
      return r;
    endfunction

    // header checks in priority order; also tracks an open header block
    function logic [3:0] frame_verdict(input logic [7:0] t, input logic [7:0] f,
                                       input logic [30:0] sid, input logic [23:0] len);
      if (in_hdr_block && (t != TypeCont || sid != hdr_block_sid)) return ChkExpCont;
      case (t)
        TypeData: return (sid == 0) ? ChkStreamZero : ChkOk;
        TypeHeaders, TypeCont: begin
          if (sid == 0) return ChkStreamZero;
          in_hdr_block = ((f & FlagEndHeaders) == 0);
          if (t == TypeHeaders) hdr_block_sid = sid;
          return ChkOk;
        end
        TypeRst: return (len != 4 || sid == 0) ? ChkRst : ChkOk;
        TypeSettings: begin
          if ((f & FlagAck) != 0) return ChkOk;
          return (len % 6 != 0) ? ChkSettings : ChkOk;
        end
        TypePushProm: return ChkPushProm;
        TypePing: return (len != 8) ? ChkPing : ChkOk;
        TypeGoaway: return (len < 8) ? ChkGoaway : ChkOk;
        TypeWinUpd: return (len != 4) ? ChkWinUpdate : ChkOk;
        default: return ChkOk;
      endcase
    endfunction

    function void note_byte(input logic [7:0] b);
      h2fd_item_t  r;
      logic [23:0] len;
      bytes_seen++;
      if (halted) return;
      if (want_preface && preface_due != 0) begin
        if (b != preface_char(int'(PrefaceLen - preface_due))) begin
          halted       = 1'b1;
          r            = '0;
          r.kind       = KindFatal;
          r.check_code = ChkPreface;
          queue_beat(r);
        end else begin
          preface_due--;
        end
        return;
      end
      if (body_left != 0) begin
        r           = stamp(KindPayload);
        r.data_byte = b;
        r.last      = (body_left == 1);
        body_left--;
        queue_beat(r);
        return;
      end
      if (hdr_fill >= HdrBytes) hdr_fill = 0;
      hdr[hdr_fill] = b;
      hdr_fill++;
      if (hdr_fill < HdrBytes) return;
      hdr_fill = 0;
      r   = stamp(KindHeader);
      len = r.frame_len;
      if (len > max_len) begin
        halted       = 1'b1;
        r.kind       = KindFatal;
        r.check_code = ChkTooLarge;
      end else begin
        r.check_code = frame_verdict(r.frame_type, r.frame_flags, r.stream_id, len);
        r.last       = (len == 0);
        body_left    = len;
      end
      queue_beat(r);
    endfunction

    function void field_cmp(input string name, input logic [31:0] got,
                            input logic [31:0] want);
      if (got !== want) begin
        report($sformatf("%s got %0h want %0h", name, got, want));
      end
    endfunction

    function void check_beat(input h2fd_item_t got);
      h2fd_item_t want;
      if (beats_due.size() == 0) begin
        report($sformatf("beat kind %0d with nothing outstanding", got.kind));
        return;
      end
      want = beats_due[0];
      beats_due.delete(0);
      field_cmp("kind", 32'(got.kind), 32'(want.kind));
      field_cmp("frame_type", 32'(got.frame_type), 32'(want.frame_type));
      field_cmp("frame_flags", 32'(got.frame_flags), 32'(want.frame_flags));
      field_cmp("stream_id", 32'(got.stream_id), 32'(want.stream_id));
      field_cmp("frame_len", 32'(got.frame_len), 32'(want.frame_len));
      field_cmp("data_byte", 32'(got.data_byte), 32'(want.data_byte));
      field_cmp("last", 32'(got.last), 32'(want.last));
      field_cmp("check_code", 32'(got.check_code), 32'(want.check_code));
      codes_seen[want.check_code] = 1'b1;
      case (want.kind)
        KindHeader:  headers_seen++;
        KindPayload: payload_seen++;
        default:     stop_code = want.check_code;
      endcase
    endfunction
  endclass

endpackage

### verif/testbench.sv
// top-level testbench for http2_frame_deframer_checker_unit: byte stimulus, random
// idling on both queue sides, beat-by-beat checking against the tracker
// depends on h2fd_pkg and h2fd_frame_model_pkg
`timescale 1ns / 1ps

module testbench;

  import h2fd_pkg::*;
  import h2fd_frame_model_pkg::*;

  localparam int WatchdogLimit = 3000;
  localparam int SettleCycles  = 10;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_push;
  logic                in_full;
  logic [7:0]          in_byte;
  logic                out_empty;
  logic                out_pop;
  logic [1:0]          out_kind;
  logic [7:0]          out_frame_type;
  logic [7:0]          out_frame_flags;
  logic [30:0]         out_stream_id;
  logic [23:0]         out_frame_len;
  logic [7:0]          out_data_byte;
  logic                out_last;
  logic [3:0]          out_check_code;
  logic                cfg_we;
  logic                cfg_idx;
  logic [CfgWidth-1:0] cfg_data;

  deframe_tracker tracker;
  h2fd_item_t     seen_beat;
  bit             in_idle  = 1'b1;
  bit             out_idle = 1'b1;
  int unsigned    quiet_cycles = 0;

  http2_frame_deframer_checker_unit uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_byte         (in_byte),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_kind        (out_kind),
    .out_frame_type  (out_frame_type),
    .out_frame_flags (out_frame_flags),
    .out_stream_id   (out_stream_id),
    .out_frame_len   (out_frame_len),
    .out_data_byte   (out_data_byte),
    .out_last        (out_last),
    .out_check_code  (out_check_code),
    .cfg_we          (cfg_we),
    .cfg_idx         (cfg_idx),
    .cfg_data        (cfg_data)
  );

  always #5 clk = ~clk;

  task automatic send_byte(input logic [7:0] b);
    if (in_idle && $urandom_range(0, 9) == 0) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_push <= 1'b1;
    in_byte <= b;
    do @(posedge clk); while (in_full);
    tracker.note_byte(b);
  endtask

  task automatic send_header(input logic [7:0] t, input logic [7:0] f,
                             input logic [31:0] sid, input logic [23:0] len);
    send_byte(len[23:16]);
    send_byte(len[15:8]);
    send_byte(len[7:0]);
    send_byte(t);
    send_byte(f);
    send_byte(sid[31:24]);
    send_byte(sid[23:16]);
    send_byte(sid[15:8]);
    send_byte(sid[7:0]);
  endtask

  task automatic send_frame(input logic [7:0] t, input logic [7:0] f,
                            input logic [31:0] sid, input logic [23:0] len);
    send_header(t, f, sid, len);
    for (int i = 0; i < len; i++) send_byte(8'($urandom_range(0, 255)));
  endtask

  // mostly well-formed frames; continuation favoured while a header block is open
  task automatic send_random_frame();
    logic [7:0]  t;
    logic [7:0]  f;
    logic [31:0] sid;
    int          len;
    int          r;
    f   = 8'($urandom_range(0, 255));
    sid = 32'($urandom_range(1, 15));
    r   = $urandom_range(0, 19);
    if (r == 0) begin
      sid = '0;
    end else if (r == 1) begin
      sid = $urandom;
    end else if (r < 5) begin
      sid[31] = 1'b1;
    end
    if (tracker.in_hdr_block && $urandom_range(0, 4) != 0) begin
      t   = TypeCont;
      sid = {1'($urandom_range(0, 1)), tracker.hdr_block_sid};
    end else begin
      r = $urandom_range(0, 11);
      if (r < 10) begin
        t = 8'(r);
      end else if (r == 10) begin
        t = 8'($urandom_range(10, 255));
      end else begin
        t = 8'($urandom_range(0, 255));
      end
    end
    case (t)
      TypeRst, TypeWinUpd: len = 4;
      TypePing:            len = 8;
      TypeGoaway:          len = $urandom_range(8, 16);
      TypeSettings:        len = 6 * $urandom_range(0, 3);
      default:             len = $urandom_range(0, 24);
    endcase
    if ($urandom_range(0, 4) == 0) len = $urandom_range(0, 24);
    if (len > tracker.max_len) len = int'(tracker.max_len);
    send_frame(t, f, sid, 24'(len));
  endtask

  task automatic settle();
    in_push <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [CfgWidth-1:0] v);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.set_reg(idx, v);
    @(posedge clk);
  endtask

  initial begin
    out_pop <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (out_idle && $urandom_range(0, 3) == 0) begin
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
      end
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      seen_beat = {out_kind, out_frame_type, out_frame_flags, out_stream_id,
                   out_frame_len, out_data_byte, out_last, out_check_code};
      tracker.check_beat(seen_beat);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("watchdog: no beat moved for %0d cycles", WatchdogLimit);
      $display("http2_frame_deframer_checker_unit: mismatch");
      $finish;
    end
  end

  initial begin : main_seq
    int k;
    int stop_mode;
    int pos;
    int lim;
    int target;
    int n;
    tracker = new();
    rst_n    <= 1'b0;
    in_push  <= 1'b0;
    in_byte  <= '0;
    cfg_we   <= 1'b0;
    cfg_idx  <= CfgExpectPreface;
    cfg_data <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_reg(CfgMaxFrameLen, MaxLenReset);
    write_reg(CfgExpectPreface, 24'd1);

    // part of the preface, then preface switched off midway
    k = $urandom_range(1, 23);
    for (int i = 0; i < k; i++) send_byte(preface_char(i));
    settle();
    write_reg(CfgExpectPreface, 24'd0);

    send_frame(TypeData, 8'h00, 32'd0, 24'd0);
    send_frame(TypeData, 8'h01, 32'd5, 24'd3);
    send_frame(TypeHeaders, FlagEndHeaders, 32'h8000_0000, 24'd0);
    send_frame(TypeHeaders, 8'h00, 32'd3, 24'd2);
    send_frame(TypeData, 8'h00, 32'd3, 24'd1);
    send_frame(TypeCont, 8'h00, 32'd7, 24'd0);
    send_frame(TypeCont, 8'h00, 32'h8000_0003, 24'd1);
    send_frame(TypeCont, FlagEndHeaders, 32'd3, 24'd0);
    send_frame(TypeCont, 8'h00, 32'd0, 24'd0);
    send_frame(TypePushProm, FlagEndHeaders, 32'd1, 24'd4);
    send_frame(TypeSettings, 8'h00, 32'd0, 24'd5);
    send_frame(TypeSettings, FlagAck, 32'd0, 24'd5);
    send_frame(TypeSettings, 8'h00, 32'd0, 24'd12);
    send_frame(TypeWinUpd, 8'h00, 32'd1, 24'd3);
    send_frame(TypeWinUpd, 8'h00, 32'd0, 24'd4);
    send_frame(TypeRst, 8'h00, 32'd0, 24'd4);
    send_frame(TypeRst, 8'h00, 32'd1, 24'd5);
    send_frame(TypeRst, 8'h00, 32'd1, 24'd4);
    send_frame(TypePing, 8'h00, 32'd0, 24'd7);
    send_frame(TypePing, FlagAck, 32'd0, 24'd8);
    send_frame(TypeGoaway, 8'h00, 32'd0, 24'd7);
    send_frame(TypeGoaway, 8'h00, 32'd0, 24'd8);
    send_frame(8'hff, 8'hff, 32'hffff_ffff, 24'd1);
    // payload exactly at a small length limit
    settle();
    write_reg(CfgMaxFrameLen, 24'd16);
    send_frame(TypeData, 8'h00, 32'd1, 24'd16);
    settle();

    for (int p = 0; p < 4; p++) begin
      case (p)
        0:       write_reg(CfgMaxFrameLen, 24'hffffff);
        1:       write_reg(CfgMaxFrameLen, 24'($urandom_range(16384, 24'hffffff)));
        2:       write_reg(CfgMaxFrameLen, 24'd64);
        default: write_reg(CfgMaxFrameLen, MaxLenReset);
      endcase
      write_reg(CfgExpectPreface, 24'd0);
      in_idle  = (p != 2);
      out_idle = (p != 2);
      target   = tracker.bytes_seen + 85;
      while (tracker.bytes_seen < target) send_random_frame();
      settle();
    end

    // closing part without idling: preface back on, then a latched stop
    in_idle  = 1'b0;
    out_idle = 1'b0;
    write_reg(CfgExpectPreface, 24'd1);
    stop_mode = $urandom_range(0, 1);
    if (stop_mode == 0) begin
      pos = $urandom_range(k, 23);
      for (int i = k; i < pos; i++) send_byte(preface_char(i));
      send_byte(preface_char(pos) ^ 8'($urandom_range(1, 255)));
    end else begin
      for (int i = k; i < PrefaceLen; i++) send_byte(preface_char(i));
      repeat (3) send_random_frame();
      settle();
      lim = $urandom_range(0, 1) ? int'(MaxLenReset) : $urandom_range(0, 200);
      write_reg(CfgMaxFrameLen, 24'(lim));
      send_header(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), $urandom,
                  24'($urandom_range(lim + 1, 24'hffffff)));
    end
    // bytes after the stop must vanish
    repeat ($urandom_range(4, 16)) send_byte(8'($urandom_range(0, 255)));
    in_push <= 1'b0;

    for (n = 0; n < WatchdogLimit && tracker.pending() != 0; n++) @(posedge clk);
    repeat (20) @(posedge clk);
    if (tracker.pending() != 0) begin
      tracker.report($sformatf("%0d beats never arrived", tracker.pending()));
    end

    $display("covered %0d bytes: %0d frame headers, %0d payload beats, check codes seen %b",
             tracker.bytes_seen, tracker.headers_seen, tracker.payload_seen,
             tracker.codes_seen);
    $display("closing stop from %s, code %0d",
             (stop_mode == 0) ? "preface mismatch" : "over-length frame", tracker.stop_code);
    if (tracker.mismatches == 0) begin
      $display("http2_frame_deframer_checker_unit: match");
    end else begin
      $display("http2_frame_deframer_checker_unit: mismatch");
    end
    $finish;
  end

endmodule
